[rtl/b64e_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants for the base64 stream encoder: queue entry
// layout, padding code and the sextet to alphabet mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam logic [6:0] PAD_CHAR = 7'h3D;

	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} slot_t;

	typedef struct packed {
		slot_t [3:0] slots;
		logic  [1:0] last_idx;
		logic        fin;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [6:0] sextet_char(input logic [5:0] s);
		logic [6:0] c;
		c = 7'h00;
		if (s < 6'd26) begin
			c = 7'd65 + {1'b0, s};
		end else if (s < 6'd52) begin
			c = 7'd71 + {1'b0, s};
		end else if (s < 6'd62) begin
			c = {1'b0, s} - 7'd4;
		end else if (s == 6'd62) begin
			c = 7'h2B;
		end else begin
			c = 7'h2F;
		end
		return c;
	endfunction

endpackage

[rtl/b64e_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_in_if
// Plain byte channel: valid/ready handshake with byte and end-of-message flag.
// ----------------------------------------------------------------------------
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/b64e_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_out_if
// Encoded character channel: valid/ready handshake with ASCII code and
// final-character flag.
// ----------------------------------------------------------------------------
interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       final_char;

	modport source (output valid, output out_char, output final_char, input ready);
	modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

[rtl/b64e_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_fifo
// Short register queue of character groups between front and back end.
// ----------------------------------------------------------------------------
module b64e_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64e_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output b64e_pkg::cmd_t    head,
	output b64e_pkg::q_stat_t stat
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64e_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		n = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
		return n;
	endfunction

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue pop while empty");

endmodule

[rtl/b64e_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Accepts plain bytes, tracks the group phase and leftover bits, and builds
// the group of sextets and padding each byte completes.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic              clk,
	input  logic              arst_n,
	b64e_in_if.sink           plain,
	input  b64e_pkg::q_stat_t stat,
	output logic              push,
	output b64e_pkg::cmd_t    push_cmd
);
	logic [1:0] phase_q;
	logic [3:0] carry_q;
	logic [1:0] phase_d;
	logic [3:0] carry_d;
	logic [7:0] b;

	assign plain.ready = !stat.full;
	assign push        = plain.valid && plain.ready;
	assign b           = plain.data_byte;

	always_comb begin
		push_cmd          = '0;
		push_cmd.fin      = plain.last_byte;
		phase_d           = b64e_pkg::PHASE_FIRST;
		carry_d           = '0;
		case (phase_q)
			b64e_pkg::PHASE_SECOND: begin
				push_cmd.slots[0].sextet = {carry_q[1:0], b[7:4]};
				push_cmd.slots[1].sextet = {b[3:0], 2'b00};
				push_cmd.slots[2].pad    = 1'b1;
				push_cmd.last_idx        = plain.last_byte ? 2'd2 : 2'd0;
				phase_d                  = b64e_pkg::PHASE_THIRD;
				carry_d                  = b[3:0];
			end
			b64e_pkg::PHASE_THIRD: begin
				push_cmd.slots[0].sextet = {carry_q, b[7:6]};
				push_cmd.slots[1].sextet = b[5:0];
				push_cmd.last_idx        = 2'd1;
			end
			default: begin
				push_cmd.slots[0].sextet = b[7:2];
				push_cmd.slots[1].sextet = {b[1:0], 4'b0000};
				push_cmd.slots[2].pad    = 1'b1;
				push_cmd.slots[3].pad    = 1'b1;
				push_cmd.last_idx        = plain.last_byte ? 2'd3 : 2'd0;
				phase_d                  = b64e_pkg::PHASE_SECOND;
				carry_d                  = {2'b00, b[1:0]};
			end
		endcase
		if (plain.last_byte) begin
			phase_d = b64e_pkg::PHASE_FIRST;
			carry_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64e_pkg::PHASE_FIRST;
			carry_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(push && plain.last_byte) |=> (phase_q == b64e_pkg::PHASE_FIRST && carry_q == '0))
		else $error("group state not cleared after last beat");

endmodule

[rtl/b64e_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the queued character groups and sends one encoded character per
// beat through an output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::cmd_t    head,
	input  b64e_pkg::q_stat_t stat,
	output logic              pop,
	b64e_out_if.source        coded
);
	logic                valid_q;
	logic [6:0]          char_q;
	logic                fin_q;
	logic [1:0]          idx_q;
	logic                load;
	logic                emit;
	logic                is_end;
	b64e_pkg::slot_t     cur;

	assign coded.valid      = valid_q;
	assign coded.out_char   = char_q;
	assign coded.final_char = fin_q;

	assign load   = !valid_q || coded.ready;
	assign emit   = load && !stat.empty;
	assign cur    = head.slots[idx_q];
	assign is_end = (idx_q == head.last_idx);
	assign pop    = emit && is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= !stat.empty;
			end
			if (emit) begin
				idx_q <= is_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= cur.pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(cur.sextet);
			fin_q  <= head.fin && is_end;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty |-> (idx_q <= head.last_idx))
		else $error("character index past end of group");

	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 2'd0))
		else $error("character index not reset after group");

endmodule

[rtl/base64_stream_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder: one plain byte per beat in, one ASCII character
// per beat out, with '=' padding and a final-character mark per message.
// ----------------------------------------------------------------------------
// path: a byte's character group is written into the queue, and its characters then pass through the output register
// throughput: one character per cycle from the output stage while the receiver is ready;
//   four characters per three bytes in steady state, and up to four characters for the last byte
//   of a message; the byte side runs ahead by the queue depth
// reset: arst_n clears group phase, leftover bits, queue and output valid
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
	parameter int unsigned QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	b64e_in_if.sink    plain,
	b64e_out_if.source coded
);
	logic              push;
	logic              pop;
	b64e_pkg::cmd_t    push_cmd;
	b64e_pkg::cmd_t    head;
	b64e_pkg::q_stat_t stat;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.plain    (plain),
		.stat     (stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	b64e_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.coded  (coded)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 stream encoder. Plain bytes are grouped
// into messages and fed through a bursty source. The receiver stalls on a
// changing pattern and holds off once for a long stretch. Every accepted byte
// runs through a bench-side encoder, and each coded character is compared
// with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          RAND_BYTES  = 300;
	localparam int          HOLD_CYCLES = 160;
	localparam int          HOLD_AT     = 120;
	localparam int          DIR_COUNT   = 22;
	localparam logic [511:0] B64_ALPHA  =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	// single bytes, a pair, triples, sextets 0..3 and 62/63, four and five bytes
	localparam logic [DIR_COUNT*8-1:0] DIR_DATA = {
		8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFB, 8'hFF, 8'hBF, 8'h00, 8'h10, 8'h83,
		8'h4D, 8'h61, 8'h6E, 8'h4D, 8'h61, 8'h6E, 8'h61,
		8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F};
	localparam logic [DIR_COUNT-1:0] DIR_LAST = 22'b1101001001001000100001;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} plain_beat_t;

	typedef struct packed {
		logic [6:0] code;
		logic       fin;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	b64e_in_if  plain_if ();
	b64e_out_if coded_if ();

	base64_stream_encoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.plain  (plain_if),
		.coded  (coded_if)
	);

	always #5 clk = ~clk;

	plain_beat_t byte_q[$];
	char_beat_t  char_q[$];

	logic [1:0] enc_phase;
	logic [3:0] enc_carry;

	int err_cnt;
	int bytes_in;
	int chars_out;
	int msgs_out;
	int burst_left;
	int gap_left;
	int hold_left;
	bit hold_done;
	int rx_cyc;
	int rx_mode;
	logic [15:0] rx_pat;

	function automatic logic [6:0] ascii_of(input logic [5:0] s);
		return B64_ALPHA[8 * (63 - int'(s)) +: 7];
	endfunction

	task automatic report(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	// encodes one byte and queues the characters it completes
	task automatic encode_byte(input logic [7:0] b, input logic last);
		logic [6:0] codes[4];
		int         n;
		char_beat_t c;
		n = 0;
		case (enc_phase)
			b64e_pkg::PHASE_SECOND: begin
				codes[n] = ascii_of({enc_carry[1:0], b[7:4]}); n++;
				enc_carry = b[3:0];
				enc_phase = b64e_pkg::PHASE_THIRD;
				if (last) begin
					codes[n] = ascii_of({b[3:0], 2'b00}); n++;
					codes[n] = b64e_pkg::PAD_CHAR; n++;
				end
			end
			b64e_pkg::PHASE_THIRD: begin
				codes[n] = ascii_of({enc_carry, b[7:6]}); n++;
				codes[n] = ascii_of(b[5:0]); n++;
				enc_carry = 4'd0;
				enc_phase = b64e_pkg::PHASE_FIRST;
			end
			default: begin
				codes[n] = ascii_of(b[7:2]); n++;
				enc_carry = {2'b00, b[1:0]};
				enc_phase = b64e_pkg::PHASE_SECOND;
				if (last) begin
					codes[n] = ascii_of({b[1:0], 4'b0000}); n++;
					codes[n] = b64e_pkg::PAD_CHAR; n++;
					codes[n] = b64e_pkg::PAD_CHAR; n++;
				end
			end
		endcase
		if (last) begin
			enc_phase = b64e_pkg::PHASE_FIRST;
			enc_carry = 4'd0;
		end
		for (int i = 0; i < n; i++) begin
			c.code = codes[i];
			c.fin  = last && (i == n - 1);
			char_q.push_back(c);
		end
	endtask

	// byte source: bursts of random length, random gaps in between
	always @(posedge clk or negedge arst_n) begin
		plain_beat_t nb;
		if (!arst_n) begin
			plain_if.valid     <= 1'b0;
			plain_if.data_byte <= 8'h00;
			plain_if.last_byte <= 1'b0;
			enc_phase  = b64e_pkg::PHASE_FIRST;
			enc_carry  = 4'd0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (plain_if.valid && plain_if.ready) begin
				encode_byte(plain_if.data_byte, plain_if.last_byte);
				bytes_in++;
			end
			if (!plain_if.valid || plain_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					plain_if.valid <= 1'b0;
				end else if (byte_q.size() != 0) begin
					nb = byte_q.pop_front();
					plain_if.valid     <= 1'b1;
					plain_if.data_byte <= nb.data;
					plain_if.last_byte <= nb.last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end else begin
					plain_if.valid <= 1'b0;
				end
			end
		end
	end

	// character sink: stall mode and pattern redrawn periodically at random, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coded_if.ready <= 1'b0;
			rx_cyc    = 0;
			rx_mode   = 0;
			rx_pat    = 16'hA5C3;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			rx_cyc++;
			if (rx_cyc % 48 == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_pat  = 16'($urandom);
			end
			if (hold_left != 0) begin
				hold_left--;
				coded_if.ready <= 1'b0;
			end else if (!hold_done && bytes_in >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				coded_if.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: coded_if.ready <= 1'b1;
					1: coded_if.ready <= 1'($urandom_range(0, 1));
					2: coded_if.ready <= ($urandom_range(0, 3) == 0);
					default: coded_if.ready <= rx_pat[rx_cyc % 16];
				endcase
			end
		end
	end

	// character checker
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && coded_if.valid && coded_if.ready) begin
			chars_out++;
			if (coded_if.final_char)
				msgs_out++;
			if (char_q.size() == 0) begin
				report($sformatf("unexpected char 0x%02h final %0b",
					coded_if.out_char, coded_if.final_char));
			end else begin
				want = char_q.pop_front();
				if (coded_if.out_char !== want.code)
					report($sformatf("char %0d: out_char 0x%02h, expected 0x%02h",
						chars_out, coded_if.out_char, want.code));
				if (coded_if.final_char !== want.fin)
					report($sformatf("char %0d: final_char %0b, expected %0b",
						chars_out, coded_if.final_char, want.fin));
			end
		end
	end

	initial begin
		plain_beat_t beat;
		int          n_rand;
		int          msg_len;
		int          waited;
		logic [7:0]  b;
		err_cnt   = 0;
		bytes_in  = 0;
		chars_out = 0;
		msgs_out  = 0;

		for (int i = 0; i < DIR_COUNT; i++) begin
			beat.data = DIR_DATA[8 * (DIR_COUNT - 1 - i) +: 8];
			beat.last = DIR_LAST[DIR_COUNT - 1 - i];
			byte_q.push_back(beat);
		end
		n_rand = 0;
		while (n_rand < RAND_BYTES) begin
			msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12);
			for (int k = 0; k < msg_len; k++) begin
				case ($urandom_range(0, 9))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				beat.data = b;
				beat.last = (k == msg_len - 1);
				byte_q.push_back(beat);
			end
			n_rand += msg_len;
		end

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_q.size() != 0 || plain_if.valid)
			@(posedge clk);
		waited = 0;
		while (char_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (char_q.size() != 0)
			report($sformatf("%0d expected chars never arrived", char_q.size()));

		$display("Encoded %0d bytes into %0d chars over %0d messages",
			bytes_in, chars_out, msgs_out);
		$display("Bursty source, varied sink stalls, one %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
